// ===== hdl/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int CODE_BITS       = 12;
  localparam int DICT_DEPTH      = 4096;
  localparam int MIN_CODE_BITS   = 9;
  localparam int MAX_CODE_BITS   = 12;
  localparam int DICT_LIMIT      = 4095;
  localparam int LIT_COUNT       = 256;
  localparam int CHUNK_BYTES_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int OUT_WORDS       = 8;
  localparam int OUT_BYTES       = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LEAF,
    ST_POP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_LITERAL,
    PH_NORMAL,
    PH_LAST
  } phase_e;

  typedef struct packed {
    logic [CODE_BITS-1:0] prefix;
    logic [7:0]           suffix;
  } dict_entry_t;

endpackage

// ===== hdl/lzwd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/lzw_variable_width_decoder.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// LZW decoder for 9 to 12 bit codes with early change, chunked byte output.
// ----------------------------------------------------------------------------
// One packed byte is taken per input word; at most one code completes per
// byte. A byte that completes no code leaves the block idle, and a bad code
// goes straight to the output word. A decoded code walks its prefix chain
// through the dictionary RAM at one byte per cycle, pushing bytes onto a
// stack RAM, then pops them at one byte per cycle into the output chunk,
// pausing while a full chunk waits on the output stall. The registered
// read ports of the dictionary and stack RAMs set this pace. Input stall
// stays high until the last chunk of a word has been taken. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder #(
  parameter int CHUNK_BYTES = lzwd_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_word0_o,
  output logic [63:0] out_word1_o,
  output logic [63:0] out_word2_o,
  output logic [63:0] out_word3_o,
  output logic [63:0] out_word4_o,
  output logic [63:0] out_word5_o,
  output logic [63:0] out_word6_o,
  output logic [63:0] out_word7_o,
  output logic [6:0]  byte_count_o,
  output logic        bad_code_o,
  output logic        last_chunk_o
);
  import lzwd_pkg::*;

  localparam int PosW = $clog2(CHUNK_BYTES);

  state_e state_q, state_d;
  phase_e phase_q;
  logic [31:0]          store_q;
  logic [5:0]           fill_q;
  logic [3:0]           width_q;
  logic [CODE_BITS-1:0] nf_q, prev_code_q, code_q, start_q;
  logic [7:0]           prev_first_q, leaf_q;
  logic                 eos_q, first_q, bad_q, rd_pend_q;
  logic [CODE_BITS-1:0] sp_q;
  logic [6:0]           pos_q;
  logic [5:0]           res_cnt_q;
  logic [CHUNK_BYTES-1:0][7:0] chunk_q;

  // unpacker
  logic [31:0]          store_ins, store_rest;
  logic [5:0]           fill_sum;
  logic                 have_code, bad_c, kwk;
  logic [CODE_BITS-1:0] code_c, node;
  logic                 accept, issue, last_c;

  dict_entry_t          dict_rd, dict_wd;
  logic                 dict_we, stk_we;
  logic [CODE_BITS-1:0] stk_waddr;
  logic [7:0]           stk_wd, stk_rd;
  logic [CODE_BITS-1:0] nf_inc;

  assign accept    = in_valid_i && !in_stall_o;
  assign store_ins = store_q | (32'(data_byte_i) << (6'd24 - fill_q));
  assign fill_sum  = fill_q + 6'd8;
  assign have_code = fill_sum >= {2'b00, width_q};
  assign code_c    = CODE_BITS'(store_ins >> (6'd32 - {2'b00, width_q}));
  assign store_rest = store_ins << width_q;
  assign bad_c     = (phase_q == PH_LITERAL) ? (code_c >= CODE_BITS'(LIT_COUNT))
                                             : (code_c > nf_q);
  assign kwk       = (code_c == nf_q);
  assign node      = first_q ? start_q : dict_rd.prefix;
  assign issue     = (sp_q != '0) && ((pos_q + 7'(rd_pend_q)) < 7'(CHUNK_BYTES));
  assign last_c    = (sp_q == '0) || (res_cnt_q == 6'(MAX_RESULTS - 1));
  assign nf_inc    = nf_q + 1'b1;
  assign dict_wd   = '{prefix: prev_code_q, suffix: leaf_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && have_code) begin
          if (bad_c) begin
            state_d = ST_EMIT;
          end else if (phase_q == PH_LITERAL) begin
            state_d = ST_LEAF;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: if (node < CODE_BITS'(LIT_COUNT)) state_d = ST_LEAF;
      ST_LEAF: state_d = ST_POP;
      ST_POP:  if (!issue && !rd_pend_q) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall_i) state_d = last_c ? ST_IDLE : ST_POP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and memory controls
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    dict_we     = (state_q == ST_LEAF) && (phase_q == PH_NORMAL);
    stk_we      = 1'b0;
    stk_waddr   = sp_q;
    stk_wd      = leaf_q;
    unique case (state_q)
      ST_IDLE: begin
        stk_we    = accept && have_code && !bad_c && (phase_q != PH_LITERAL) && kwk;
        stk_waddr = '0;
        stk_wd    = prev_first_q;
      end
      ST_WALK: begin
        stk_we = !first_q;
        stk_wd = dict_rd.suffix;
      end
      ST_LEAF: stk_we = 1'b1;
      default: stk_we = 1'b0;
    endcase
  end

  lzwd_ram #(.WIDTH($bits(dict_entry_t)), .DEPTH(DICT_DEPTH)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nf_q),
    .wdata_i (dict_wd),
    .raddr_i (node),
    .rdata_o (dict_rd)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wd),
    .raddr_i (sp_q - 1'b1),
    .rdata_o (stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_LITERAL;
      store_q      <= '0;
      fill_q       <= '0;
      width_q      <= 4'(MIN_CODE_BITS);
      nf_q         <= CODE_BITS'(LIT_COUNT);
      prev_code_q  <= '0;
      prev_first_q <= '0;
      eos_q        <= 1'b0;
      first_q      <= 1'b0;
      bad_q        <= 1'b0;
      rd_pend_q    <= 1'b0;
      sp_q         <= '0;
      pos_q        <= '0;
      res_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            chunk_q   <= '0;
            pos_q     <= '0;
            res_cnt_q <= '0;
            bad_q     <= have_code && bad_c;
            eos_q     <= end_of_stream_i;
            code_q    <= code_c;
            leaf_q    <= code_c[7:0];
            first_q   <= 1'b1;
            sp_q      <= '0;
            if (end_of_stream_i) begin
              store_q <= '0;
              fill_q  <= '0;
            end else if (have_code) begin
              store_q <= store_rest;
              fill_q  <= fill_sum - {2'b00, width_q};
            end else begin
              store_q <= store_ins;
              fill_q  <= fill_sum;
            end
            if (have_code && !bad_c && phase_q != PH_LITERAL) begin
              if (kwk) begin
                sp_q    <= CODE_BITS'(1);
                start_q <= prev_code_q;
              end else begin
                start_q <= code_c;
              end
            end
            // restart now unless a valid code is still to be decoded
            if (end_of_stream_i && !(have_code && !bad_c)) begin
              nf_q         <= CODE_BITS'(LIT_COUNT);
              width_q      <= 4'(MIN_CODE_BITS);
              prev_code_q  <= '0;
              prev_first_q <= '0;
              phase_q      <= PH_LITERAL;
            end
          end
        end
        ST_WALK: begin
          first_q <= 1'b0;
          if (!first_q) sp_q <= sp_q + 1'b1;
          leaf_q <= node[7:0];
        end
        ST_LEAF: begin
          sp_q  <= sp_q + 1'b1;
          pos_q <= '0;
          case (phase_q)
            PH_LITERAL: begin
              prev_code_q  <= code_q;
              prev_first_q <= leaf_q;
              phase_q      <= PH_NORMAL;
            end
            PH_NORMAL: begin
              nf_q         <= nf_inc;
              prev_code_q  <= code_q;
              prev_first_q <= leaf_q;
              if (nf_inc >= CODE_BITS'(DICT_LIMIT)) begin
                phase_q <= PH_LAST;
              end else if (({1'b0, nf_inc} + 1'b1) == (13'd1 << width_q) &&
                           width_q < 4'(MAX_CODE_BITS)) begin
                width_q <= width_q + 1'b1;
              end
            end
            default: begin
              nf_q    <= CODE_BITS'(LIT_COUNT);
              width_q <= 4'(MIN_CODE_BITS);
              phase_q <= PH_LITERAL;
            end
          endcase
          if (eos_q) begin
            nf_q         <= CODE_BITS'(LIT_COUNT);
            width_q      <= 4'(MIN_CODE_BITS);
            prev_code_q  <= '0;
            prev_first_q <= '0;
            phase_q      <= PH_LITERAL;
          end
        end
        ST_POP: begin
          rd_pend_q <= issue;
          if (issue) sp_q <= sp_q - 1'b1;
          if (rd_pend_q) begin
            chunk_q[pos_q[PosW-1:0]] <= stk_rd;
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            res_cnt_q <= res_cnt_q + 1'b1;
            chunk_q   <= '0;
            pos_q     <= '0;
            bad_q     <= 1'b0;
            // drop what remains once the result limit is hit
            if (last_c) sp_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  logic [OUT_BYTES-1:0][7:0] bytes_w;

  for (genvar i = 0; i < OUT_BYTES; i++) begin : g_bytes
    if (i < CHUNK_BYTES) begin : g_used
      assign bytes_w[i] = chunk_q[i];
    end else begin : g_zero
      assign bytes_w[i] = '0;
    end
  end

  assign out_word0_o  = bytes_w[7:0];
  assign out_word1_o  = bytes_w[15:8];
  assign out_word2_o  = bytes_w[23:16];
  assign out_word3_o  = bytes_w[31:24];
  assign out_word4_o  = bytes_w[39:32];
  assign out_word5_o  = bytes_w[47:40];
  assign out_word6_o  = bytes_w[55:48];
  assign out_word7_o  = bytes_w[63:56];
  assign byte_count_o = pos_q;
  assign bad_code_o   = bad_q;
  assign last_chunk_o = last_c;

endmodule

// ===== hdl/lzwd_chk.sv =====
// ----------------------------------------------------------------------------
// lzwd_chk
// Port-level checks for the LZW decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzwd_chk #(
  parameter int CHUNK_BYTES = lzwd_pkg::CHUNK_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  byte_count_o,
  input logic        bad_code_o,
  input logic        last_chunk_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_count_o))
    else $error("stalled word changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a word is pending");

  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_code_o |-> byte_count_o == 7'd0 && last_chunk_o)
    else $error("bad code word malformed");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_chunk_o |-> byte_count_o == 7'(CHUNK_BYTES))
    else $error("non-final chunk not full");

endmodule

bind lzw_variable_width_decoder lzwd_chk #(.CHUNK_BYTES(CHUNK_BYTES)) u_lzwd_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .byte_count_o (byte_count_o),
  .bad_code_o   (bad_code_o),
  .last_chunk_o (last_chunk_o)
);

// ===== tb/tb_lzw_variable_width_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzw_variable_width_decoder
// Self-checking bench for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
// A short table of directed bytes runs first. It covers bad literals,
// extreme bytes, an end of stream with no code, and codes that are not yet
// defined. Random code streams follow, mixed with raw noise bytes. A
// bit-exact predictor checks every output chunk. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_lzw_variable_width_decoder;
  import lzwd_pkg::*;

  localparam int CHUNK     = CHUNK_BYTES_DEF;
  localparam int MAX_CYCLE = 2000000;

  typedef struct {
    logic [511:0] data;
    logic [6:0]   cnt;
    logic         bad;
    logic         last;
  } chunk_t;

  typedef struct {
    logic [7:0]  b;
    logic        e;
    bit          typed;
    logic [63:0] w0;
    int          cnt;
    bit          bad;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_word0_o, out_word1_o, out_word2_o, out_word3_o;
  logic [63:0] out_word4_o, out_word5_o, out_word6_o, out_word7_o;
  logic [6:0]  byte_count_o;
  logic        bad_code_o;
  logic        last_chunk_o;

  lzw_variable_width_decoder DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Decoder model state
  logic [11:0] dict_prefix [DICT_DEPTH];
  logic [7:0]  dict_suffix [DICT_DEPTH];
  logic [7:0]  dict_first  [DICT_DEPTH];
  logic [7:0]  walk_stack  [DICT_DEPTH];
  logic [7:0]  str_bytes   [DICT_DEPTH+2];
  int          free_slot, width;
  logic [31:0] bit_acc;
  int          bit_cnt;
  int          prev_code;
  logic [7:0]  prev_first;
  phase_e      phase;

  chunk_t      chunk_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          n_sent = 0;

  // Code stream generator state, mirrors the dictionary growth rules
  int          gen_free, gen_width;
  phase_e      gen_phase;
  bit          gen_wrapped;
  logic [63:0] pack_acc;
  int          pack_bits;
  logic [7:0]  pack_q [$];

  function automatic void restart_model();
    free_slot  = LIT_COUNT;
    width      = MIN_CODE_BITS;
    bit_acc    = '0;
    bit_cnt    = 0;
    prev_code  = 0;
    prev_first = 8'h00;
    phase      = PH_LITERAL;
  endfunction

  function automatic int expand_code(int code);
    int depth, len, c;
    depth = 0;
    len   = 0;
    c     = code & 12'hFFF;
    while (c >= LIT_COUNT && depth < DICT_DEPTH - 1) begin
      walk_stack[depth] = dict_suffix[c];
      depth++;
      c = dict_prefix[c];
    end
    walk_stack[depth] = c[7:0];
    depth++;
    while (depth > 0) begin
      depth--;
      str_bytes[len] = walk_stack[depth];
      len++;
    end
    return len;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic e);
    int     len, code, slot, nchunks, cnt;
    bit     bad;
    chunk_t ch;
    len = 0;
    bad = 0;
    bit_acc = bit_acc | ({24'h0, b} << (24 - bit_cnt));
    bit_cnt += 8;
    if (bit_cnt >= width) begin
      code    = int'(bit_acc >> (32 - width));
      bit_acc = bit_acc << width;
      bit_cnt -= width;
      if (phase == PH_LITERAL) begin
        if (code < LIT_COUNT) begin
          str_bytes[0] = code[7:0];
          len        = 1;
          prev_code  = code;
          prev_first = code[7:0];
          phase      = PH_NORMAL;
        end else begin
          bad = 1;
        end
      end else begin
        if (code < free_slot) begin
          len = expand_code(code);
        end else if (code == free_slot) begin
          len = expand_code(prev_code);
          str_bytes[len] = prev_first;
          len++;
        end else begin
          bad = 1;
        end
        if (!bad && phase == PH_NORMAL) begin
          slot = free_slot & 12'hFFF;
          dict_prefix[slot] = prev_code[11:0];
          dict_suffix[slot] = str_bytes[0];
          dict_first[slot]  = prev_first;
          free_slot++;
          prev_code  = code;
          prev_first = (code < LIT_COUNT) ? code[7:0] : dict_first[code];
          if (free_slot >= DICT_LIMIT) begin
            phase = PH_LAST;
          end else if (free_slot + 1 == (1 << width) && width < MAX_CODE_BITS) begin
            width++;
          end
        end else if (!bad) begin
          free_slot = LIT_COUNT;
          width     = MIN_CODE_BITS;
          phase     = PH_LITERAL;
        end
      end
    end
    if (e) restart_model();
    if (len == 0 && !bad) return;
    nchunks = (len == 0) ? 1 : (len + CHUNK - 1) / CHUNK;
    if (nchunks > MAX_RESULTS) nchunks = MAX_RESULTS;
    for (int k = 0; k < nchunks; k++) begin
      cnt = len - k * CHUNK;
      if (cnt > CHUNK) cnt = CHUNK;
      if (cnt < 0) cnt = 0;
      ch.data = '0;
      for (int i = 0; i < cnt; i++) ch.data[8*i +: 8] = str_bytes[k*CHUNK + i];
      ch.cnt  = cnt[6:0];
      ch.bad  = bad;
      ch.last = (k + 1 == nchunks);
      chunk_q.push_back(ch);
    end
  endfunction

  // Drive one word, hold it until taken, then idle between bursts
  task automatic send_byte(logic [7:0] b, logic e, row_t r);
    int     n_before;
    chunk_t ch;
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    n_before = chunk_q.size();
    decode_byte(b, e);
    if (r.typed) begin
      while (chunk_q.size() > n_before) void'(chunk_q.pop_back());
      ch.data = {448'h0, r.w0};
      ch.cnt  = r.cnt[6:0];
      ch.bad  = r.bad;
      ch.last = 1'b1;
      chunk_q.push_back(ch);
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_plain(logic [7:0] b, logic e);
    row_t r;
    r.typed = 0;
    send_byte(b, e, r);
  endtask

  function automatic void gen_restart();
    gen_free  = LIT_COUNT;
    gen_width = MIN_CODE_BITS;
    gen_phase = PH_LITERAL;
  endfunction

  // Pick the next code and advance the mirrored dictionary growth
  function automatic int gen_code(int bad_pct);
    int  code, top, r;
    bit  want_bad;
    top      = (1 << gen_width) - 1;
    want_bad = ($urandom_range(0, 99) < bad_pct);
    if (gen_phase == PH_LITERAL) begin
      if (want_bad) return $urandom_range(LIT_COUNT, top);
      code = $urandom_range(0, 255);
      gen_phase = PH_NORMAL;
      return code;
    end
    if (want_bad && gen_free < top) return $urandom_range(gen_free + 1, top);
    r = $urandom_range(0, 99);
    if (r < 4)       code = gen_free;
    else if (r < 7)  code = gen_free - 1;
    else if (r < 9)  code = 0;
    else if (r < 11) code = 255;
    else             code = $urandom_range(0, gen_free);
    if (gen_phase == PH_NORMAL) begin
      gen_free++;
      if (gen_free >= DICT_LIMIT) begin
        gen_phase = PH_LAST;
      end else if (gen_free + 1 == (1 << gen_width) && gen_width < MAX_CODE_BITS) begin
        gen_width++;
      end
    end else begin
      gen_restart();
      gen_wrapped = 1;
    end
    return code;
  endfunction

  function automatic void pack_code(int code, int w);
    pack_acc  = (pack_acc << w) | 64'(code);
    pack_bits += w;
    while (pack_bits >= 8) begin
      pack_q.push_back(8'(pack_acc >> (pack_bits - 8)));
      pack_bits -= 8;
    end
  endfunction

  // Build a code stream, pad it to a byte and mark its last word
  task automatic send_stream(int ncodes, int bad_pct, bit until_wrap);
    int w, code, n;
    gen_restart();
    gen_wrapped = 0;
    pack_acc    = '0;
    pack_bits   = 0;
    pack_q.delete();
    n = 0;
    while (until_wrap ? !(gen_wrapped && n > ncodes) : n < ncodes) begin
      w    = gen_width;
      code = gen_code(bad_pct);
      pack_code(code, w);
      if (gen_wrapped && until_wrap) n++;
      if (!until_wrap) n++;
    end
    if (pack_bits > 0) pack_code($urandom_range(0, (1 << (8 - pack_bits)) - 1), 8 - pack_bits);
    foreach (pack_q[i]) send_plain(pack_q[i], (i == pack_q.size() - 1));
  endtask

  // Receiver stall: quiet, random and long-hold stretches, chosen at random
  int stall_mode = 0;
  int stall_hold = 0;
  always @(posedge clk_i) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    if (stall_hold > 0) begin
      stall_hold  <= stall_hold - 1;
      out_stall_i <= 1'b1;
    end else if (stall_mode == 1) begin
      out_stall_i <= $urandom_range(0, 1);
    end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
      stall_hold  <= $urandom_range(1, 20);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each taken chunk with the oldest expected one
  always @(posedge clk_i) begin
    chunk_t ex;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (chunk_q.size() == 0) begin
        $display("%0t: unexpected chunk, count %0d bad %0b", $time, byte_count_o,
                 bad_code_o);
        errors++;
      end else begin
        ex = chunk_q.pop_front();
        if ({out_word7_o, out_word6_o, out_word5_o, out_word4_o,
             out_word3_o, out_word2_o, out_word1_o, out_word0_o} !== ex.data) begin
          $display("%0t: data expected %h actual %h", $time, ex.data,
                   {out_word7_o, out_word6_o, out_word5_o, out_word4_o,
                    out_word3_o, out_word2_o, out_word1_o, out_word0_o});
          errors++;
        end
        if (byte_count_o !== ex.cnt) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, ex.cnt, byte_count_o);
          errors++;
        end
        if (bad_code_o !== ex.bad) begin
          $display("%0t: bad_code expected %0b actual %0b", $time, ex.bad, bad_code_o);
          errors++;
        end
        if (last_chunk_o !== ex.last) begin
          $display("%0t: last_chunk expected %0b actual %0b", $time, ex.last, last_chunk_o);
          errors++;
        end
      end
    end
    if (cycles > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t dir_tab [15];

  initial begin
    dir_tab = '{
      '{8'hFF, 1'b0, 0, 64'h0, 0, 0},
      '{8'h80, 1'b1, 1, 64'h0, 0, 1},          // bad literal, all ones
      '{8'h7F, 1'b0, 0, 64'h0, 0, 0},
      '{8'h80, 1'b1, 1, 64'hFF, 1, 0},         // literal 0xFF
      '{8'h00, 1'b0, 0, 64'h0, 0, 0},
      '{8'h00, 1'b1, 1, 64'h00, 1, 0},         // literal 0x00
      '{8'h5A, 1'b1, 0, 64'h0, 0, 0},          // end of stream, no code
      '{8'h20, 1'b0, 0, 64'h0, 0, 0},
      '{8'hC0, 1'b0, 1, 64'h41, 1, 0},
      '{8'h20, 1'b0, 1, 64'h4141, 2, 0},       // code not yet defined
      '{8'h20, 1'b1, 1, 64'h414141, 3, 0},
      '{8'hAA, 1'b0, 0, 64'h0, 0, 0},
      '{8'h55, 1'b0, 0, 64'h0, 0, 0},
      '{8'hFF, 1'b0, 0, 64'h0, 0, 0},
      '{8'h00, 1'b1, 0, 64'h0, 0, 0}
    };
    for (int i = 0; i < DICT_DEPTH; i++) begin
      dict_prefix[i] = '0;
      dict_suffix[i] = '0;
      dict_first[i]  = '0;
    end
    restart_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].e, dir_tab[i]);

    // hold off until the block has drained
    in_valid_i <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    while (n_sent < 100) begin
      if ($urandom_range(0, 4) == 0) begin
        send_plain($urandom_range(0, 255), ($urandom_range(0, 4) == 0));
      end else begin
        send_stream($urandom_range(3, 25), $urandom_range(0, 1) ? 0 : 8, 0);
      end
    end

    in_valid_i <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && chunk_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lzwd_pkg.sv
hdl/lzwd_ram.sv
hdl/lzw_variable_width_decoder.sv
hdl/lzwd_chk.sv
tb/tb_lzw_variable_width_decoder.sv
